@@ design/glos_pkg.sv @@
// Shared types and constants for the grid line-of-sight block.
`timescale 1ns / 1ps
`default_nettype none

package glos_pkg;

   // Field widths of the request and result beats
   localparam int X_W     = 8;
   localparam int Y_W     = 6;
   localparam int FEAT_W  = 4;
   localparam int THR_W   = 4;

   // Signed walk coordinates and the scaled error term
   localparam int COORD_W = 10;
   localparam int ERR_W   = 2 * COORD_W;

   localparam logic [THR_W-1:0] THR_RESET = 4'd12;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_HALF,
      ST_MUL_ERR,
      ST_INIT,
      ST_READ,
      ST_TEST,
      ST_DECIDE,
      ST_SIDE,
      ST_DONE
   } glos_state_type;

   typedef enum logic {
      ERR_ADD_SLOPE,
      ERR_SUB_FULL
   } glos_err_op_type;

   typedef struct packed {
      logic lt;
      logic gt;
   } glos_cmp_type;

   typedef struct packed {
      logic [X_W-1:0] from_x;
      logic [Y_W-1:0] from_y;
      logic [X_W-1:0] to_x;
      logic [Y_W-1:0] to_y;
   } glos_query_type;

   typedef struct packed {
      logic valid;
      logic visible;
   } glos_result_type;

endpackage

`default_nettype wire

@@ design/grid_line_of_sight_top.sv @@
// Top level of the grid line-of-sight block: map RAM, sequencer, CSR and result register.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a GRID_WIDTH x GRID_HEIGHT map of feature codes and answers line-of-sight
// queries over it. A write beat (mode 0) stores one tile's code and gives no result;
// writes outside the grid are dropped. A query beat (mode 1) walks the line from tile
// centre to tile centre along the longer axis and returns one visible beat: 1 when
// every tile passed (end tiles excluded) is below closed_threshold, 0 as soon as one
// blocks or the walk leaves the grid. Tiles at most one apart in each axis are always
// visible. Any other query first decodes, forms two products on one multiplier and takes
// the start step; then each step along the longer axis reads and tests one tile, on a
// sloped line updates the error term, and when it enters a new row or column also
// tests the side tile. The longest walk has 254 steps and up to 63 side tiles. The pace
// is set by the single read port of the map RAM (one tile per test, read data
// registered) and the one shared error-term adder. The block takes no request while a
// query is in flight; the result sits in an output register, so a new request is taken
// while the previous result waits, and a finished query holds until that register is
// free. closed_threshold must be written through the csr_ port (always ready) only
// while the block is idle; the block itself does not enforce this. It resets to 12.
// Every tile must be written before a query reads it.

module grid_line_of_sight_top
   import glos_pkg::*;
#(
   parameter int GRID_WIDTH   = 256,
   parameter int GRID_HEIGHT  = 64,
   parameter int FEATURE_BITS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_mode,
   input  wire logic [X_W-1:0]    req_from_x,
   input  wire logic [Y_W-1:0]    req_from_y,
   input  wire logic [X_W-1:0]    req_to_x,
   input  wire logic [Y_W-1:0]    req_to_y,
   input  wire logic [FEAT_W-1:0] req_tile_feature,

   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_visible,

   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [THR_W-1:0]  csr_wdata
);

   localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   // threshold register
   logic [THR_W-1:0] thr_ff, thr_in;

   assign csr_ready = 1'b1;
   assign thr_in    = (csr_valid && csr_ready) ? csr_wdata : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // request beat
   logic           seq_ready;
   logic           req_accept;
   glos_query_type query;

   assign req_stall    = !seq_ready;
   assign req_accept   = req_valid && seq_ready;
   assign query.from_x = req_from_x;
   assign query.from_y = req_from_y;
   assign query.to_x   = req_to_x;
   assign query.to_y   = req_to_y;

   // map write path
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [FEATURE_BITS-1:0] wr_data;

   assign wr_en   = req_accept && (req_mode == MODE_WRITE)
                    && (req_from_x < GRID_WIDTH) && (req_from_y < GRID_HEIGHT);
   assign wr_addr = ADDR_W'(ADDR_W'(req_from_y) * ADDR_W'(GRID_WIDTH))
                    + ADDR_W'(req_from_x);
   assign wr_data = FEATURE_BITS'(req_tile_feature);

   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [FEATURE_BITS-1:0] rd_data;

   glos_ram #(
      .WIDTH (FEATURE_BITS),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_visible_ff, rsp_visible_in;
   logic            rsp_free;
   glos_result_type done;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   glos_seq #(
      .GRID_WIDTH   (GRID_WIDTH),
      .GRID_HEIGHT  (GRID_HEIGHT),
      .FEATURE_BITS (FEATURE_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .query_start (req_accept && (req_mode == MODE_QUERY)),
      .query       (query),
      .ready       (seq_ready),
      .rsp_free    (rsp_free),
      .done        (done),
      .thr         (thr_ff),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   assign rsp_valid_in   = done.valid || (rsp_valid_ff && rsp_stall);
   assign rsp_visible_in = done.valid ? done.visible : rsp_visible_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_visible_ff <= rsp_visible_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

endmodule

`default_nettype wire

@@ design/glos_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module glos_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/glos_err.sv @@
// Shared error-term adder and half-point compare for the line walk.
`timescale 1ns / 1ps
`default_nettype none

module glos_err
   import glos_pkg::*;
(
   input  wire logic signed [ERR_W-1:0] err,
   input  wire logic signed [ERR_W-1:0] slope,
   input  wire logic signed [ERR_W-1:0] half,
   input  wire glos_err_op_type          op,
   output logic signed      [ERR_W-1:0] sum,
   output glos_cmp_type                  cmp
);

   logic signed [ERR_W-1:0] full;
   logic signed [ERR_W-1:0] operand;

   assign full = half <<< 1;

   always_comb begin
      unique case (op)
         ERR_ADD_SLOPE: operand = slope;
         ERR_SUB_FULL:  operand = -full;
         default:       operand = '0;
      endcase
   end

   assign sum    = err + operand;
   assign cmp.lt = err < half;
   assign cmp.gt = err > half;

endmodule

`default_nettype wire

@@ design/glos_seq.sv @@
// Query sequencer: setup, multiplier steps and the tile walk over the map.
`timescale 1ns / 1ps
`default_nettype none

module glos_seq
   import glos_pkg::*;
#(
   parameter int GRID_WIDTH   = 256,
   parameter int GRID_HEIGHT  = 64,
   parameter int FEATURE_BITS = 4
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        query_start,
   input  wire glos_query_type                              query,
   output logic                                             ready,
   input  wire logic                                        rsp_free,
   output glos_result_type                                  done,
   input  wire logic [THR_W-1:0]                            thr,
   output logic                                             rd_en,
   output logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]        rd_addr,
   input  wire logic [FEATURE_BITS-1:0]                     rd_data
);

   localparam int ADDR_W = $clog2(GRID_WIDTH * GRID_HEIGHT);

   glos_state_type state_ff, state_in;

   logic signed [COORD_W-1:0] a_ff, a_in;
   logic signed [COORD_W-1:0] b_ff, b_in;
   logic signed [COORD_W-1:0] a1_ff, a1_in;
   logic signed [COORD_W-1:0] da_ff, da_in;
   logic signed [COORD_W-1:0] db_ff, db_in;
   logic                      swap_ff, swap_in;
   logic signed [ERR_W-1:0]   half_ff, half_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W-1:0]   slope_ff, slope_in;
   logic                      vis_ff, vis_in;

   // request decode
   logic signed [COORD_W-1:0] fx, fy, tx, ty, dx, dy, adx, ady;
   logic                      adj, x_major;

   assign fx  = signed'(COORD_W'(query.from_x));
   assign fy  = signed'(COORD_W'(query.from_y));
   assign tx  = signed'(COORD_W'(query.to_x));
   assign ty  = signed'(COORD_W'(query.to_y));
   assign dx  = tx - fx;
   assign dy  = ty - fy;
   assign adx = (dx < 0) ? -dx : dx;
   assign ady = (dy < 0) ? -dy : dy;
   assign adj = (dx > -2) && (dx < 2) && (dy > -2) && (dy < 2);
   assign x_major = adx >= ady;

   // shared multiplier: da*db, then db*db
   logic signed [COORD_W-1:0] mul_a;
   logic signed [ERR_W-1:0]   prod;

   assign mul_a = (state_ff == ST_MUL_HALF) ? da_ff : db_ff;
   assign prod  = mul_a * db_ff;

   // walk steps
   logic signed [COORD_W-1:0] step_a, step_b;
   logic                      straight;

   assign step_a   = da_ff[COORD_W-1] ? '1 : COORD_W'(1);
   assign step_b   = db_ff[COORD_W-1] ? '1 : COORD_W'(1);
   assign straight = db_ff == '0;

   // probe tile: side tile while deciding, else the main tile
   logic signed [COORD_W-1:0] probe_b, px, py;
   logic                      oob, blocked;

   assign probe_b = (state_ff == ST_DECIDE) ? (b_ff + step_b) : b_ff;
   assign px      = swap_ff ? probe_b : a_ff;
   assign py      = swap_ff ? a_ff : probe_b;
   assign oob     = (px < 0) || (px >= GRID_WIDTH) || (py < 0) || (py >= GRID_HEIGHT);
   assign rd_addr = ADDR_W'(ADDR_W'($unsigned(py)) * ADDR_W'(GRID_WIDTH))
                    + ADDR_W'($unsigned(px));
   assign blocked = 32'(rd_data) >= 32'(thr);

   glos_err_op_type         err_op;
   logic signed [ERR_W-1:0] err_sum;
   glos_cmp_type            err_cmp;

   glos_err u_err (
      .err   (err_ff),
      .slope (slope_ff),
      .half  (half_ff),
      .op    (err_op),
      .sum   (err_sum),
      .cmp   (err_cmp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      a1_ff    <= a1_in;
      da_ff    <= da_in;
      db_ff    <= db_in;
      swap_ff  <= swap_in;
      half_ff  <= half_in;
      err_ff   <= err_in;
      slope_ff <= slope_in;
      vis_ff   <= vis_in;
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      a1_in    = a1_ff;
      da_in    = da_ff;
      db_in    = db_ff;
      swap_in  = swap_ff;
      half_in  = half_ff;
      err_in   = err_ff;
      slope_in = slope_ff;
      vis_in   = vis_ff;
      rd_en    = 1'b0;
      err_op   = ERR_SUB_FULL;
      done     = '0;
      ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (query_start) begin
               swap_in = !x_major;
               a_in    = x_major ? fx : fy;
               b_in    = x_major ? fy : fx;
               a1_in   = x_major ? tx : ty;
               da_in   = x_major ? dx : dy;
               db_in   = x_major ? dy : dx;
               if (adj) begin
                  vis_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL_HALF;
               end
            end
         end
         ST_MUL_HALF: begin
            half_in  = (prod < 0) ? -prod : prod;
            state_in = ST_MUL_ERR;
         end
         ST_MUL_ERR: begin
            err_in   = prod;
            slope_in = prod <<< 1;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            a_in = a_ff + step_a;
            // line leaves the start tile through a corner
            if (!straight && (err_ff == half_ff)) begin
               b_in   = b_ff + step_b;
               err_in = err_sum;
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            if (a_ff == a1_ff) begin
               vis_in   = 1'b1;
               state_in = ST_DONE;
            end else if (oob) begin
               vis_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (blocked) begin
               vis_in   = 1'b0;
               state_in = ST_DONE;
            end else if (straight) begin
               a_in     = a_ff + step_a;
               state_in = ST_READ;
            end else begin
               err_op   = ERR_ADD_SLOPE;
               err_in   = err_sum;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (err_cmp.lt) begin
               a_in     = a_ff + step_a;
               state_in = ST_READ;
            end else if (err_cmp.gt) begin
               // new row or column: side tile first
               b_in   = b_ff + step_b;
               err_in = err_sum;
               if (oob) begin
                  vis_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_SIDE;
               end
            end else begin
               a_in     = a_ff + step_a;
               b_in     = b_ff + step_b;
               err_in   = err_sum;
               state_in = ST_READ;
            end
         end
         ST_SIDE: begin
            if (blocked) begin
               vis_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               a_in     = a_ff + step_a;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               done.valid   = 1'b1;
               done.visible = vis_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for grid_line_of_sight_top: map writes, sight queries, threshold CSR.
`timescale 1ns / 1ps

module tb_top;
   import glos_pkg::*;

   localparam int GRID_W      = 256;
   localparam int GRID_H      = 64;
   localparam int GRID_CELLS  = GRID_W * GRID_H;
   localparam int WIN_W       = 24;
   localparam int WIN_H       = 12;
   localparam int ITEM_TARGET = 500;
   localparam int SETTLE      = 20;
   localparam int CYCLE_LIMIT = 2_000_000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_mode;
   logic [X_W-1:0]    req_from_x;
   logic [Y_W-1:0]    req_from_y;
   logic [X_W-1:0]    req_to_x;
   logic [Y_W-1:0]    req_to_y;
   logic [FEAT_W-1:0] req_tile_feature;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_visible;
   logic              csr_valid;
   logic              csr_ready;
   logic [THR_W-1:0]  csr_wdata;

   // Per-side idling: quiet flags give stretches with no gaps at all
   bit quiet_tx;
   bit quiet_rx;
   int stall_left;
   int cycle_count;
   // Every accepted request beat, path fills included
   int beats_sent;

   // Mirror of the tile map and threshold; predicts one visible bit per query
   class sight_board;
      logic [FEAT_W-1:0] tile_map [GRID_CELLS];
      bit                tile_written [GRID_CELLS];
      logic [THR_W-1:0]  threshold;
      bit                visible_q [$];
      int                path_q [$];
      int                n_fail;

      function new();
         threshold = THR_RESET;
         n_fail    = 0;
      endfunction

      // In gather mode a tile inside the grid is only recorded and never blocks,
      // so the path gets listed up to where it leaves the grid
      function bit probe(int a, int b, bit swapped, bit gather);
         int x;
         int y;
         x = swapped ? b : a;
         y = swapped ? a : b;
         if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H)
            return 1'b1;
         if (gather) begin
            path_q.push_back(y * GRID_W + x);
            return 1'b0;
         end
         return tile_map[y * GRID_W + x] >= threshold;
      endfunction

      // Walk along the major axis a; err is scaled by 2*|da*db|
      function bit walk_line(int a0, int b0, int a1, int da, int db, bit swapped,
                             bit gather);
         int half;
         int full;
         int sa;
         int sb;
         int err;
         int slope;
         int a;
         int b;
         half = da * db;
         if (half < 0)
            half = -half;
         full  = half * 2;
         sa    = (da < 0) ? -1 : 1;
         sb    = (db < 0) ? -1 : 1;
         err   = db * db;
         slope = err * 2;
         a     = a0 + sa;
         if (err == half) begin
            b = b0 + sb;
            err -= full;
         end else begin
            b = b0;
         end
         while (a != a1) begin
            if (probe(a, b, swapped, gather))
               return 1'b0;
            err += slope;
            if (err < half) begin
               a += sa;
            end else if (err > half) begin
               // entering a new minor row/column: side tile is tested too
               b += sb;
               if (probe(a, b, swapped, gather))
                  return 1'b0;
               a += sa;
               err -= full;
            end else begin
               // exact corner crossing: step diagonally
               a += sa;
               b += sb;
               err -= full;
            end
         end
         return 1'b1;
      endfunction

      function bit trace_line(int fx, int fy, int tx, int ty, bit gather);
         int dx;
         int dy;
         int lo;
         int hi;
         int adx;
         int ady;
         dx = tx - fx;
         dy = ty - fy;
         if (dx < 2 && dx > -2 && dy < 2 && dy > -2)
            return 1'b1;
         if (dx == 0) begin
            lo = (dy < 0) ? ty : fy;
            hi = (dy < 0) ? fy : ty;
            for (int y = lo + 1; y < hi; y++)
               if (probe(fx, y, 1'b0, gather))
                  return 1'b0;
            return 1'b1;
         end
         if (dy == 0) begin
            lo = (dx < 0) ? tx : fx;
            hi = (dx < 0) ? fx : tx;
            for (int x = lo + 1; x < hi; x++)
               if (probe(x, fy, 1'b0, gather))
                  return 1'b0;
            return 1'b1;
         end
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         if (adx >= ady)
            return walk_line(fx, fy, tx, dx, dy, 1'b0, gather);
         return walk_line(fy, fx, ty, dy, dx, 1'b1, gather);
      endfunction

      function void note_request(logic mode, int fx, int fy, int tx, int ty,
                                 logic [FEAT_W-1:0] feat);
         if (mode == MODE_WRITE) begin
            if (fx < GRID_W && fy < GRID_H) begin
               tile_map[fy * GRID_W + fx]     = feat;
               tile_written[fy * GRID_W + fx] = 1'b1;
            end
         end else begin
            visible_q.push_back(trace_line(fx, fy, tx, ty, 1'b0));
         end
      endfunction

      function void check_result(logic vis);
         bit want;
         if (visible_q.size() == 0) begin
            $error("visible: no result expected, got %0d", vis);
            n_fail++;
         end else begin
            want = visible_q.pop_front();
            if (vis !== want) begin
               $error("visible: expected %0d, got %0d", want, vis);
               n_fail++;
            end
         end
      endfunction
   endclass

   sight_board board = new();

   grid_line_of_sight_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_from_x       (req_from_x),
      .req_from_y       (req_from_y),
      .req_to_x         (req_to_x),
      .req_to_y         (req_to_y),
      .req_tile_feature (req_tile_feature),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_visible      (rsp_visible),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: sample at the rising edge, then hold stall for a drawn count
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_visible);
         stall_left = quiet_rx ? 0 : $urandom_range(0, 15);
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Mostly transparent codes so that longer lines come out clear now and then
   function automatic int open_feature();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(0, 15);
   endfunction

   // Called and returns at a falling edge; valid stays high on return
   task automatic send_beat(logic mode, int fx, int fy, int tx, int ty, int feat);
      int gap;
      gap = quiet_tx ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode         = mode;
      req_from_x       = fx[X_W-1:0];
      req_from_y       = fy[Y_W-1:0];
      req_to_x         = tx[X_W-1:0];
      req_to_y         = ty[Y_W-1:0];
      req_tile_feature = feat[FEAT_W-1:0];
      req_valid        = 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request(mode, fx, fy, tx, ty, feat[FEAT_W-1:0]);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic put_tile(int x, int y, int feat);
      send_beat(MODE_WRITE, x, y, $urandom_range(0, GRID_W - 1),
                $urandom_range(0, GRID_H - 1), feat);
   endtask

   // Every tile on the path is written first, so no query reads an unwritten entry
   task automatic send_query(int fx, int fy, int tx, int ty);
      int path [$];
      board.path_q.delete();
      void'(board.trace_line(fx, fy, tx, ty, 1'b1));
      path = board.path_q;
      foreach (path[i])
         if (!board.tile_written[path[i]])
            put_tile(path[i] % GRID_W, path[i] / GRID_W, open_feature());
      send_beat(MODE_QUERY, fx, fy, tx, ty, $urandom_range(0, 15));
   endtask

   // Hold off until every result is back, then let the block settle
   task automatic drain_block();
      req_valid = 1'b0;
      while (board.visible_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_threshold(int thr);
      drain_block();
      csr_wdata = thr[THR_W-1:0];
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      board.threshold = thr[THR_W-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_item(int wx, int wy);
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         if ($urandom_range(0, 99) < 85)
            put_tile(wx + $urandom_range(0, WIN_W - 1), wy + $urandom_range(0, WIN_H - 1),
                     $urandom_range(0, 15));
         else
            put_tile($urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1),
                     $urandom_range(0, 15));
      end else begin
         send_query(wx + $urandom_range(0, WIN_W - 1), wy + $urandom_range(0, WIN_H - 1),
                    wx + $urandom_range(0, WIN_W - 1), wy + $urandom_range(0, WIN_H - 1));
      end
   endtask

   initial begin
      int phase_end;
      int wx;
      int wy;
      int thr;
      cycle_count      = 0;
      beats_sent       = 0;
      stall_left       = 0;
      quiet_tx         = 1'b0;
      quiet_rx         = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_WRITE;
      req_from_x       = '0;
      req_from_y       = '0;
      req_to_x         = '0;
      req_to_y         = '0;
      req_tile_feature = '0;
      csr_valid        = 1'b0;
      csr_wdata        = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, each line shape, a wall, adjacent and same tile
      put_tile(0, 0, 0);
      put_tile(GRID_W - 1, GRID_H - 1, 15);
      put_tile(GRID_W - 1, 0, 8);
      put_tile(0, GRID_H - 1, 3);
      send_query(5, 5, 5, 5);
      send_query(0, 0, 1, 1);
      send_query(GRID_W - 1, GRID_H - 1, GRID_W - 2, GRID_H - 2);
      put_tile(10, 4, 15);
      send_query(5, 4, 20, 4);
      send_query(20, 4, 5, 4);
      send_query(5, 6, 20, 6);
      send_query(10, 0, 10, 10);
      send_query(10, GRID_H - 1, 10, 1);
      send_query(4, 4, 6, 4);
      send_query(4, 4, 6, 5);
      send_query(2, 2, 12, 12);
      send_query(12, 12, 2, 2);
      send_query(0, 0, 30, 7);
      send_query(3, 1, 8, 40);
      send_query(30, 7, 0, 0);
      send_query(40, 10, 20, 30);

      // Random phases, each under its own threshold; the first keeps the reset value.
      // One window for all phases, so its tiles are filled once and then reused.
      wx = $urandom_range(0, GRID_W - WIN_W);
      wy = $urandom_range(0, GRID_H - WIN_H);
      for (int p = 0; p < 6; p++) begin
         case (p)
            1: thr = 0;
            2: thr = 15;
            5: thr = THR_RESET;
            default: thr = $urandom_range(1, 14);
         endcase
         if (p > 0)
            set_threshold(thr);
         phase_end = beats_sent + (ITEM_TARGET - beats_sent) / (6 - p);
         for (int n = 0; beats_sent < phase_end; n++) begin
            if (n % 30 == 0) begin
               quiet_tx = ($urandom_range(0, 3) == 0);
               quiet_rx = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 59) == 0)
               drain_block();
            random_item(wx, wy);
         end
      end

      drain_block();
      if (board.n_fail == 0 && board.visible_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
